>>> design/mrw_pkg.sv
// shared constants, types and sequencer states for the miller-rabin witness test
package mrw_pkg;

  // width of the arithmetic (low bits of modulus and base that take part)
  localparam int OPERAND_WIDTH = 32;
  // bit counter width for one serial multiply and for the power-of-two count
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  // fixed field and register widths
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register map: index taken from paddr[ADDR_W-1]
  localparam logic REG_IDX_MODULUS = 1'b0;
  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd3;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  localparam operand_t ONE = operand_t'(1);

  // request into the serial modular multiplier
  typedef struct packed {
    logic     start;
    operand_t x;
    operand_t y;
    operand_t m;
  } mm_req_t;

  // response from the serial modular multiplier
  typedef struct packed {
    logic     done;
    operand_t p;
  } mm_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_REDUCE,
    ST_PSTEP,
    ST_PMUL,
    ST_PSHIFT,
    ST_PSQ,
    ST_PEND,
    ST_CHECK,
    ST_SQUARE,
    ST_DONE
  } seq_state_t;

endpackage

>>> design/mrw_channels.sv
// valid/ready channel interfaces for witness items and result items
interface mrw_in_if;
  logic                     valid;
  logic                     ready;
  logic [mrw_pkg::DATA_W-1:0] witness_base;

  modport source (output valid, output witness_base, input ready);
  modport sink (input valid, input witness_base, output ready);
endinterface

interface mrw_out_if;
  logic valid;
  logic ready;
  logic probable_prime;

  modport source (output valid, output probable_prime, input ready);
  modport sink (input valid, input probable_prime, output ready);
endinterface

>>> design/mrw_modmul.sv
// bit-serial interleaved modular multiplier: p = x * y mod m, one bit of x per cycle
module mrw_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  mrw_pkg::mm_req_t req,
  output mrw_pkg::mm_rsp_t rsp
);

  localparam int W = mrw_pkg::OPERAND_WIDTH;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [mrw_pkg::CNT_W-1:0] cnt_r;
  mrw_pkg::operand_t       x_r, y_r, m_r, acc_r;

  logic [W+1:0] sum;
  logic [W+1:0] two_m;
  logic [W+1:0] red1;
  logic [W+1:0] red2;

  // acc = 2*acc + bit*y, then bring back below m (sum stays under 3m)
  always_comb begin
    sum   = {1'b0, acc_r, 1'b0} + {2'b00, (x_r[W-1] ? y_r : '0)};
    two_m = {1'b0, m_r, 1'b0};
    red1  = (sum >= two_m) ? (sum - two_m) : sum;
    red2  = (red1 >= {2'b00, m_r}) ? (red1 - {2'b00, m_r}) : red1;
  end

  // control next state
  always_comb begin
    busy_nxt = req.start | (busy_r & (cnt_r != '0));
    done_nxt = busy_r & (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operand shift register and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x;
      y_r   <= req.y;
      m_r   <= req.m;
      acc_r <= '0;
      cnt_r <= mrw_pkg::CNT_W'(W - 1);
    end else if (busy_r) begin
      x_r   <= {x_r[W-2:0], 1'b0};
      acc_r <= red2[W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

>>> design/mrw_seq.sv
// round sequencer: splits m-1, runs square-and-multiply and the squaring chain
module mrw_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mrw_pkg::operand_t base,
  input  mrw_pkg::operand_t m,
  output logic              idle,
  output logic              res_valid,
  output logic              res_bit,
  input  logic              res_ready,
  output mrw_pkg::mm_req_t  mm_req,
  input  mrw_pkg::mm_rsp_t  mm_rsp
);

  localparam int W = mrw_pkg::OPERAND_WIDTH;

  mrw_pkg::seq_state_t state_r, state_nxt;
  mrw_pkg::operand_t   a_r, a_nxt;
  mrw_pkg::operand_t   e_r, e_nxt;
  mrw_pkg::operand_t   acc_r, acc_nxt;
  mrw_pkg::operand_t   sq_r, sq_nxt;
  logic [mrw_pkg::CNT_W-1:0] s_r, s_nxt;
  logic [mrw_pkg::CNT_W-1:0] j_r, j_nxt;
  logic                res_r, res_nxt;
  mrw_pkg::operand_t   m_minus1;

  assign m_minus1 = m - mrw_pkg::ONE;

  // next state, multiplier requests and result
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    e_nxt     = e_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    s_nxt     = s_r;
    j_nxt     = j_r;
    res_nxt   = res_r;
    mm_req.start = 1'b0;
    mm_req.x     = acc_r;
    mm_req.y     = sq_r;
    mm_req.m     = m;
    res_valid    = 1'b0;

    unique case (state_r)
      mrw_pkg::ST_IDLE: begin
        if (start) begin
          a_nxt = base;
          // even modulus or modulus of one: composite, no arithmetic
          if (!m[0] || (m == mrw_pkg::ONE)) begin
            res_nxt   = 1'b0;
            state_nxt = mrw_pkg::ST_DONE;
          end else begin
            e_nxt     = m_minus1;
            s_nxt     = '0;
            state_nxt = mrw_pkg::ST_SPLIT;
          end
        end
      end
      // strip trailing zeros of m-1, one per cycle
      mrw_pkg::ST_SPLIT: begin
        if (!e_r[0]) begin
          e_nxt = {1'b0, e_r[W-1:1]};
          s_nxt = s_r + 1'b1;
        end else begin
          mm_req.start = 1'b1;
          mm_req.x     = a_r;
          mm_req.y     = mrw_pkg::ONE;
          state_nxt    = mrw_pkg::ST_REDUCE;
        end
      end
      // base reduced modulo m
      mrw_pkg::ST_REDUCE: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.p;
          acc_nxt   = mrw_pkg::ONE;
          state_nxt = mrw_pkg::ST_PSTEP;
        end
      end
      mrw_pkg::ST_PSTEP: begin
        if (e_r[0]) begin
          mm_req.start = 1'b1;
          state_nxt    = mrw_pkg::ST_PMUL;
        end else begin
          state_nxt = mrw_pkg::ST_PSHIFT;
        end
      end
      mrw_pkg::ST_PMUL: begin
        if (mm_rsp.done) begin
          acc_nxt   = mm_rsp.p;
          state_nxt = mrw_pkg::ST_PSHIFT;
        end
      end
      // next exponent bit; square only while bits remain
      mrw_pkg::ST_PSHIFT: begin
        e_nxt = {1'b0, e_r[W-1:1]};
        if (e_r[W-1:1] != '0) begin
          mm_req.start = 1'b1;
          mm_req.x     = sq_r;
          state_nxt    = mrw_pkg::ST_PSQ;
        end else begin
          state_nxt = mrw_pkg::ST_PEND;
        end
      end
      mrw_pkg::ST_PSQ: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.p;
          state_nxt = mrw_pkg::ST_PSTEP;
        end
      end
      mrw_pkg::ST_PEND: begin
        if (acc_r == mrw_pkg::ONE) begin
          res_nxt   = 1'b1;
          state_nxt = mrw_pkg::ST_DONE;
        end else begin
          j_nxt     = mrw_pkg::CNT_W'(1);
          state_nxt = mrw_pkg::ST_CHECK;
        end
      end
      // squaring chain looking for m-1
      mrw_pkg::ST_CHECK: begin
        if (acc_r == m_minus1) begin
          res_nxt   = 1'b1;
          state_nxt = mrw_pkg::ST_DONE;
        end else if (j_r >= s_r) begin
          res_nxt   = 1'b0;
          state_nxt = mrw_pkg::ST_DONE;
        end else begin
          mm_req.start = 1'b1;
          mm_req.y     = acc_r;
          state_nxt    = mrw_pkg::ST_SQUARE;
        end
      end
      mrw_pkg::ST_SQUARE: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.p;
          // a one before m-1 proves compositeness
          if (mm_rsp.p == mrw_pkg::ONE) begin
            res_nxt   = 1'b0;
            state_nxt = mrw_pkg::ST_DONE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = mrw_pkg::ST_CHECK;
          end
        end
      end
      mrw_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = mrw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    e_r   <= e_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    s_r   <= s_nxt;
    j_r   <= j_nxt;
    res_r <= res_nxt;
  end

  assign idle    = (state_r == mrw_pkg::ST_IDLE);
  assign res_bit = res_r;

endmodule

>>> design/miller_rabin_witness_test.sv
// top level: one miller-rabin round per witness item against the modulus register
//
//   channel  | dir | handshake             | payload
//   in_ch    | in  | valid/ready           | witness_base[31:0]
//   out_ch   | out | valid/ready           | probable_prime
//   apb      | in  | psel/penable/pready   | modulus at byte address 0
//
// one item at a time; each modular product runs on the bit-serial multiplier, then the
// sequencer takes its result; products: base reduction, set bits of r, bits of r less one
// squarings and up to s-1 more; an invalid modulus goes straight to the result without
// any arithmetic
// rst_n is synchronous; modulus resets to 3
// the result register lets the next item in while a result waits on out_ch.ready
module miller_rabin_witness_test (
  input  logic                        clk,
  input  logic                        rst_n,
  mrw_in_if.sink                      in_ch,
  mrw_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrw_pkg::ADDR_W-1:0]  paddr,
  input  logic [mrw_pkg::DATA_W-1:0]  pwdata,
  output logic [mrw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int W = mrw_pkg::OPERAND_WIDTH;

  logic [mrw_pkg::DATA_W-1:0] modulus_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_bit_r;
  logic                       seq_idle;
  logic                       res_valid;
  logic                       res_bit;
  logic                       res_ready;
  logic                       item_start;
  mrw_pkg::mm_req_t           mm_req;
  mrw_pkg::mm_rsp_t           mm_rsp;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[mrw_pkg::ADDR_W-1] == mrw_pkg::REG_IDX_MODULUS) ? modulus_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mrw_pkg::MODULUS_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr[mrw_pkg::ADDR_W-1] == mrw_pkg::REG_IDX_MODULUS)) begin
      modulus_r <= pwdata;
    end
  end

  // input side
  assign in_ch.ready = seq_idle;
  assign item_start  = in_ch.valid & seq_idle;

  mrw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (item_start),
    .base      (in_ch.witness_base[W-1:0]),
    .m         (modulus_r[W-1:0]),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_bit   (res_bit),
    .res_ready (res_ready),
    .mm_req    (mm_req),
    .mm_rsp    (mm_rsp)
  );

  mrw_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // result register
  assign res_ready = ~out_valid_r | out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_bit_r <= res_bit;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.probable_prime = out_bit_r;

endmodule

>>> design/mrw_checker.sv
// port-level checks for the witness test block, bound to the top level
module mrw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // items accepted and not yet delivered
  always_comb begin
    pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // one item in the works at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input ready right after an item was accepted");

  // no result without an item behind it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result offered with no outstanding item");

  // at most one item in the sequencer and one waiting result
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd3))
    else $error("too many outstanding items");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bit))
    else $error("stalled result dropped or changed");

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_bit   (out_ch.probable_prime)
);

>>> tb/tb.sv
// testbench for miller_rabin_witness_test: witness items checked against a local predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register index with no register behind it; writes there must be dropped
  localparam logic REG_IDX_UNUSED = 1'b1;
  localparam int IDLE_PCT = 13;
  localparam int PHASE_ITEMS = 9;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mrw_pkg::ADDR_W-1:0] paddr;
  logic [mrw_pkg::DATA_W-1:0] pwdata;
  logic [mrw_pkg::DATA_W-1:0] prdata;
  logic pready;

  mrw_in_if witness_ch ();
  mrw_out_if verdict_ch ();

  miller_rabin_witness_test DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (witness_ch),
    .out_ch  (verdict_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the modulus register and the verdicts still owed by the block
  logic [mrw_pkg::DATA_W-1:0] modulus_reg;
  logic expected_verdicts[$];
  bit no_idle = 1'b0;
  int failures = 0;
  int items_sent = 0;
  int verdicts_checked = 0;
  int primes_seen = 0;
  int moduli_applied = 0;

  always #5 clk = ~clk;

  // residue product at full 64-bit width
  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x * y) % m;
  endfunction

  // right-to-left square-and-multiply
  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] expo,
                                          logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % m;
    sq = base;
    while (expo != 0) begin
      if (expo[0]) acc = mul_mod(acc, sq, m);
      expo >>= 1;
      if (expo != 0) sq = mul_mod(sq, sq, m);
    end
    return acc;
  endfunction

  // one strong-probable-prime round; invalid modulus gives composite
  function automatic logic predict_probable_prime(
      logic [mrw_pkg::DATA_W-1:0] modulus_val,
      logic [mrw_pkg::DATA_W-1:0] base_raw);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] y;
    int unsigned s;
    int unsigned j;
    m = 64'(mrw_pkg::operand_t'(modulus_val));
    a = 64'(mrw_pkg::operand_t'(base_raw));
    if (m < 3 || m[0] == 1'b0) return 1'b0;
    r = m - 1;
    s = 0;
    while (r[0] == 1'b0) begin
      r >>= 1;
      s++;
    end
    y = pow_mod(a % m, r, m);
    if (y == 1 || y == m - 1) return 1'b1;
    for (j = 1; j < s && y != m - 1; j++) begin
      y = mul_mod(y, y, m);
      if (y == 1) return 1'b0;
    end
    return (y == m - 1);
  endfunction

  function automatic logic [mrw_pkg::ADDR_W-1:0] reg_addr(logic idx);
    return {idx, 2'b00};
  endfunction

  // result side: random back-pressure, none during the quiet stretch
  always @(negedge clk) begin
    verdict_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_verdict
    logic want;
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result item: probable_prime actual %0b", verdict_ch.probable_prime);
        failures++;
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (verdict_ch.probable_prime === 1'b1) primes_seen++;
        if (verdict_ch.probable_prime !== want) begin
          $error("probable_prime mismatch: expected %0b, actual %0b",
                 want, verdict_ch.probable_prime);
          failures++;
        end
      end
    end
  end

  // one witness item; valid stays up until the next call or park_input
  task automatic send_witness(input logic [mrw_pkg::DATA_W-1:0] base);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      witness_ch.valid <= 1'b0;
      @(negedge clk);
    end
    witness_ch.valid <= 1'b1;
    witness_ch.witness_base <= base;
    do @(posedge clk); while (!witness_ch.ready);
    expected_verdicts.push_back(predict_probable_prime(modulus_reg, base));
    items_sent++;
  endtask

  task automatic park_input();
    @(negedge clk);
    witness_ch.valid <= 1'b0;
  endtask

  // block is idle once every verdict is back
  task automatic wait_drained();
    park_input();
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // setup then access; leaves psel high for a back-to-back transfer
  task automatic apb_transfer(input logic wr, input logic [mrw_pkg::ADDR_W-1:0] addr,
                              input logic [mrw_pkg::DATA_W-1:0] wdata,
                              output logic [mrw_pkg::DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr[mrw_pkg::ADDR_W-1] == mrw_pkg::REG_IDX_MODULUS) modulus_reg = wdata;
  endtask

  // write a register, read the modulus back and release the bus
  task automatic write_reg(input logic idx, input logic [mrw_pkg::DATA_W-1:0] value);
    logic [mrw_pkg::DATA_W-1:0] rdata;
    wait_drained();
    apb_transfer(1'b1, reg_addr(idx), value, rdata);
    apb_transfer(1'b0, reg_addr(mrw_pkg::REG_IDX_MODULUS), '0, rdata);
    if (rdata !== modulus_reg) begin
      $error("modulus readback mismatch: expected %0d, actual %0d", modulus_reg, rdata);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == mrw_pkg::REG_IDX_MODULUS) moduli_applied++;
  endtask

  // modulus left at its reset value
  task automatic test_reset_modulus();
    send_witness(32'd0);
    send_witness(32'd1);
    send_witness(32'd2);
    send_witness(32'd3);
    send_witness(32'd4);
    send_witness(32'hFFFF_FFFF);
  endtask

  // zero, one, two and even moduli answer composite without arithmetic
  task automatic test_invalid_moduli();
    logic [mrw_pkg::DATA_W-1:0] bad[4] = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFE};
    foreach (bad[i]) begin
      write_reg(mrw_pkg::REG_IDX_MODULUS, bad[i]);
      send_witness($urandom);
    end
  endtask

  // write to the unused index must leave the modulus alone
  task automatic test_ignored_register();
    write_reg(mrw_pkg::REG_IDX_MODULUS, 32'd2047);
    write_reg(REG_IDX_UNUSED, 32'd65537);
    send_witness(32'd2);
  endtask

  // bases at zero, one, minus one and the modulus itself, then further moduli against small bases
  task automatic test_special_bases();
    write_reg(mrw_pkg::REG_IDX_MODULUS, 32'd4294967291);
    send_witness(32'd0);
    send_witness(32'd1);
    send_witness(32'd4294967290);
    send_witness(32'd4294967291);
    send_witness(32'hFFFF_FFFF);
    send_witness(32'd2);
    // carmichael number against base two
    write_reg(mrw_pkg::REG_IDX_MODULUS, 32'd561);
    send_witness(32'd2);
    send_witness(32'd1122);
    // prime with a long run of squarings
    write_reg(mrw_pkg::REG_IDX_MODULUS, 32'd3221225473);
    send_witness(32'd5);
    write_reg(mrw_pkg::REG_IDX_MODULUS, 32'hFFFF_FFFF);
    send_witness(32'd2);
  endtask

  // random bases over a spread of moduli, mostly random values with some edges
  task automatic test_random_phases();
    logic [mrw_pkg::DATA_W-1:0] moduli[$];
    logic [mrw_pkg::DATA_W-1:0] m;
    logic [mrw_pkg::DATA_W-1:0] base;
    logic [63:0] mult;
    int pick;
    moduli = {32'd4294967291, 32'd2147483647, 32'd3215031751, 32'd3221225473,
              32'd2047, 32'd65537, 32'd97, 32'd3, 32'hFFFF_FFFF, 32'd561};
    moduli.push_back($urandom | 32'd1);
    moduli.push_back($urandom | 32'h8000_0001);
    moduli.push_back(32'($urandom_range(3, 4095)) | 32'd1);
    moduli.push_back($urandom & ~32'd1);
    foreach (moduli[p]) begin
      write_reg(mrw_pkg::REG_IDX_MODULUS, moduli[p]);
      m = moduli[p];
      no_idle = (p >= 4 && p <= 6);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          base = $urandom;
        end else if (pick < 75) begin
          base = $urandom_range(2, 100);
        end else if (m < 3) begin
          base = $urandom_range(0, 3);
        end else begin
          case ($urandom_range(4))
            0: base = 32'd0;
            1: base = 32'd1;
            2: base = m - 32'd1;
            3: base = m + 32'd1;
            default: begin
              mult = 64'(m) * $urandom_range(1, 32'hFFFF_FFFF / m);
              base = mult[mrw_pkg::DATA_W-1:0];
            end
          endcase
        end
        send_witness(base);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    witness_ch.valid = 1'b0;
    witness_ch.witness_base = '0;
    verdict_ch.ready = 1'b0;
    modulus_reg = mrw_pkg::MODULUS_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_modulus();
    test_invalid_moduli();
    test_ignored_register();
    test_special_bases();
    test_random_phases();

    // drain and leave room for any stray result
    wait_drained();
    repeat (50) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("%0d expected verdicts never arrived", expected_verdicts.size());
      failures++;
    end

    $display("summary: %0d witness items over %0d modulus settings, %0d verdicts compared",
             items_sent, moduli_applied, verdicts_checked);
    $display("summary: %0d probable-prime verdicts, %0d failures", primes_seen, failures);
    if (failures == 0) begin
      $display("** miller_rabin_witness_test: PASSED **");
    end else begin
      $display("** miller_rabin_witness_test: FAILED **");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout: %0d verdicts still outstanding", expected_verdicts.size());
    $display("** miller_rabin_witness_test: FAILED **");
    $finish;
  end

endmodule

>>> miller_rabin_witness_test.f
design/mrw_pkg.sv
design/mrw_channels.sv
design/mrw_modmul.sv
design/mrw_seq.sv
design/miller_rabin_witness_test.sv
design/mrw_checker.sv
tb/tb.sv
